// ----- hdl/mpm_pkg.sv -----
// package with sizes, node record, codes and state encoding of the pattern matcher
`default_nettype none
package mpm_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int MAX_PAT_LEN = 63;
  localparam int NW          = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int LEN_W       = $clog2(MAX_PAT_LEN + 1);
  localparam int ID_W        = 16;

  typedef struct packed {
    logic [7:0]      nbyte;
    logic [NW-1:0]   child;
    logic [NW-1:0]   sib;
    logic [NW-1:0]   fail;
    logic            mark;
    logic [ID_W-1:0] pid;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_MATCH = 2'd3
  } act_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_MATCH = 1'b1;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_F_RD,
    S_F_PW,
    S_F_SC,
    S_F_CW,
    S_A_GOT,
    S_A_NEW,
    S_A_PAR,
    S_A_FIN,
    S_A_MRK,
    S_M_GOT,
    S_M_CH,
    S_M_CW,
    S_B_INIT,
    S_B_POP,
    S_B_QW,
    S_B_NW,
    S_B_C,
    S_B_CW,
    S_B_GOT,
    S_B_WR
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/mpm_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/multi_pattern_matcher.sv -----
// top level of the aho-corasick byte matcher: control sequencer around node and queue rams
// clear ends in the done result; add passes siblings, may allocate a node and complete a pattern,
// and also ends in a done result for a byte of a dropped pattern
// match makes fail hops (passing siblings, ending on a hit) and then walks the fail-chain nodes
// build visits each node and runs a find per child; one transaction at a time, busy high
// reports are never stalled; after reset the init state writes the root
`default_nettype none
module multi_pattern_matcher (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_action,
  input  wire logic [7:0]              in_data_byte,
  input  wire logic                    in_first,
  input  wire logic                    in_final_byte,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [mpm_pkg::ID_W-1:0]     out_pattern_id,
  output logic [1:0]                   out_status,
  output logic                         out_last
);

  mpm_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [mpm_pkg::NW-1:0]    cursor_r, cursor_nxt;
  logic [mpm_pkg::CNT_W-1:0] ncount_r, ncount_nxt;
  logic [mpm_pkg::ID_W-1:0]  pcount_r, pcount_nxt;
  logic [mpm_pkg::LEN_W-1:0] plen_r, plen_nxt;
  logic                      pdrop_r, pdrop_nxt;
  logic [1:0]                preason_r, preason_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      fin_r, fin_nxt;
  logic [7:0]                fbyte_r, fbyte_nxt;
  logic [mpm_pkg::NW-1:0]    fnode_r, fnode_nxt;
  logic [mpm_pkg::NW-1:0]    sc_r, sc_nxt;
  logic                      found_r, found_nxt;
  mpm_pkg::node_t            fw_r, fw_nxt;
  mpm_pkg::node_t            cw_r, cw_nxt;
  logic [mpm_pkg::NW-1:0]    f_r, f_nxt;
  logic [mpm_pkg::NW-1:0]    now_r, now_nxt;
  logic [mpm_pkg::NW-1:0]    nf_r, nf_nxt;
  logic [mpm_pkg::NW-1:0]    c_r, c_nxt;
  logic [mpm_pkg::CNT_W-1:0] head_r, head_nxt, tail_r, tail_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_kind_r, out_kind_nxt;
  logic [mpm_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      node_we;
  logic [mpm_pkg::NW-1:0]    node_waddr, node_raddr;
  mpm_pkg::node_t            node_wdata, node_rdata;
  logic                      q_we;
  logic [mpm_pkg::NW-1:0]    q_waddr, q_raddr, q_wdata, q_rdata;

  logic                      accept;
  mpm_pkg::act_t             act;
  logic                      eff_drop;
  logic [mpm_pkg::LEN_W-1:0] eff_len;
  logic [mpm_pkg::NW-1:0]    eff_cur;
  logic                      add_skip;

  mpm_ram #(.WIDTH(mpm_pkg::NODE_BITS), .DEPTH(mpm_pkg::MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  mpm_ram #(.WIDTH(mpm_pkg::NW), .DEPTH(mpm_pkg::MAX_NODES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign busy     = (state_r != mpm_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign act      = mpm_pkg::act_t'(in_action);
  assign eff_drop = in_first ? 1'b0 : pdrop_r;
  assign eff_len  = in_first ? '0 : plen_r;
  assign eff_cur  = in_first ? '0 : cursor_r;
  assign add_skip = eff_drop || (eff_len >= mpm_pkg::LEN_W'(mpm_pkg::MAX_PAT_LEN));

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_pattern_id = out_id_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpm_pkg::S_INIT: state_nxt = mpm_pkg::S_IDLE;
      mpm_pkg::S_IDLE: begin
        if (accept) begin
          case (act)
            mpm_pkg::ACT_CLEAR: state_nxt = mpm_pkg::S_CLR;
            mpm_pkg::ACT_ADD:   state_nxt = add_skip ? mpm_pkg::S_A_FIN : mpm_pkg::S_F_RD;
            mpm_pkg::ACT_BUILD: state_nxt = mpm_pkg::S_B_INIT;
            mpm_pkg::ACT_MATCH: state_nxt = mpm_pkg::S_F_RD;
            default:            state_nxt = mpm_pkg::S_IDLE;
          endcase
        end
      end
      mpm_pkg::S_CLR:   state_nxt = mpm_pkg::S_IDLE;
      mpm_pkg::S_F_RD:  state_nxt = mpm_pkg::S_F_PW;
      mpm_pkg::S_F_PW:  state_nxt = mpm_pkg::S_F_SC;
      mpm_pkg::S_F_SC:  state_nxt = (sc_r == '0) ? ret_r : mpm_pkg::S_F_CW;
      mpm_pkg::S_F_CW:  state_nxt = (node_rdata.nbyte == fbyte_r) ? ret_r : mpm_pkg::S_F_SC;
      mpm_pkg::S_A_GOT: begin
        if (found_r) begin
          state_nxt = mpm_pkg::S_A_FIN;
        end else if (ncount_r < mpm_pkg::CNT_W'(mpm_pkg::MAX_NODES)) begin
          state_nxt = mpm_pkg::S_A_NEW;
        end else begin
          state_nxt = mpm_pkg::S_A_FIN;
        end
      end
      mpm_pkg::S_A_NEW: state_nxt = mpm_pkg::S_A_PAR;
      mpm_pkg::S_A_PAR: state_nxt = mpm_pkg::S_A_FIN;
      mpm_pkg::S_A_FIN: state_nxt = (fin_r && !pdrop_r) ? mpm_pkg::S_A_MRK : mpm_pkg::S_IDLE;
      mpm_pkg::S_A_MRK: state_nxt = mpm_pkg::S_IDLE;
      mpm_pkg::S_M_GOT: begin
        state_nxt = (found_r || fnode_r == '0) ? mpm_pkg::S_M_CH : mpm_pkg::S_F_RD;
      end
      mpm_pkg::S_M_CH:  state_nxt = (f_r == '0) ? mpm_pkg::S_IDLE : mpm_pkg::S_M_CW;
      mpm_pkg::S_M_CW:  state_nxt = mpm_pkg::S_M_CH;
      mpm_pkg::S_B_INIT: state_nxt = mpm_pkg::S_B_POP;
      mpm_pkg::S_B_POP: state_nxt = (head_r == tail_r) ? mpm_pkg::S_IDLE : mpm_pkg::S_B_QW;
      mpm_pkg::S_B_QW:  state_nxt = mpm_pkg::S_B_NW;
      mpm_pkg::S_B_NW:  state_nxt = mpm_pkg::S_B_C;
      mpm_pkg::S_B_C:   state_nxt = (c_r == '0) ? mpm_pkg::S_B_POP : mpm_pkg::S_B_CW;
      mpm_pkg::S_B_CW:  state_nxt = (now_r == '0) ? mpm_pkg::S_B_WR : mpm_pkg::S_F_RD;
      mpm_pkg::S_B_GOT: begin
        state_nxt = (found_r || fnode_r == '0) ? mpm_pkg::S_B_WR : mpm_pkg::S_F_RD;
      end
      mpm_pkg::S_B_WR:  state_nxt = mpm_pkg::S_B_C;
      default:          state_nxt = mpm_pkg::S_IDLE;
    endcase
  end

  // datapath, ram control and results
  always_comb begin
    ret_nxt        = ret_r;
    cursor_nxt     = cursor_r;
    ncount_nxt     = ncount_r;
    pcount_nxt     = pcount_r;
    plen_nxt       = plen_r;
    pdrop_nxt      = pdrop_r;
    preason_nxt    = preason_r;
    byte_nxt       = byte_r;
    fin_nxt        = fin_r;
    fbyte_nxt      = fbyte_r;
    fnode_nxt      = fnode_r;
    sc_nxt         = sc_r;
    found_nxt      = found_r;
    fw_nxt         = fw_r;
    cw_nxt         = cw_r;
    f_nxt          = f_r;
    now_nxt        = now_r;
    nf_nxt         = nf_r;
    c_nxt          = c_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    node_we        = 1'b0;
    node_waddr     = '0;
    node_wdata     = '0;
    node_raddr     = '0;
    q_we           = 1'b0;
    q_waddr        = '0;
    q_wdata        = '0;
    q_raddr        = '0;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = mpm_pkg::KIND_DONE;
    out_id_nxt     = '0;
    out_status_nxt = mpm_pkg::ST_OK;
    out_last_nxt   = 1'b1;

    case (state_r)
      mpm_pkg::S_INIT: begin
        node_we = 1'b1;
      end
      mpm_pkg::S_IDLE: begin
        if (accept) begin
          byte_nxt  = in_data_byte;
          fbyte_nxt = in_data_byte;
          fin_nxt   = in_final_byte;
          case (act)
            mpm_pkg::ACT_CLEAR: begin
              ncount_nxt  = mpm_pkg::CNT_W'(1);
              cursor_nxt  = '0;
              plen_nxt    = '0;
              pdrop_nxt   = 1'b0;
              preason_nxt = mpm_pkg::ST_OK;
            end
            mpm_pkg::ACT_ADD: begin
              cursor_nxt  = eff_cur;
              plen_nxt    = eff_len;
              pdrop_nxt   = eff_drop;
              preason_nxt = in_first ? mpm_pkg::ST_OK : preason_r;
              if (!eff_drop && add_skip) begin
                pdrop_nxt   = 1'b1;
                preason_nxt = mpm_pkg::ST_LONG;
              end
              fnode_nxt = eff_cur;
              ret_nxt   = mpm_pkg::S_A_GOT;
            end
            mpm_pkg::ACT_BUILD: begin
              cursor_nxt = '0;
            end
            mpm_pkg::ACT_MATCH: begin
              fnode_nxt = eff_cur;
              ret_nxt   = mpm_pkg::S_M_GOT;
            end
            default: begin
              ret_nxt = ret_r;
            end
          endcase
        end
      end
      mpm_pkg::S_CLR: begin
        node_we       = 1'b1;
        out_valid_nxt = 1'b1;
      end
      mpm_pkg::S_F_RD: begin
        node_raddr = fnode_r;
      end
      mpm_pkg::S_F_PW: begin
        fw_nxt = node_rdata;
        sc_nxt = node_rdata.child;
      end
      mpm_pkg::S_F_SC: begin
        node_raddr = sc_r;
        found_nxt  = 1'b0;
      end
      mpm_pkg::S_F_CW: begin
        if (node_rdata.nbyte == fbyte_r) begin
          found_nxt = 1'b1;
        end else begin
          sc_nxt = node_rdata.sib;
        end
      end
      mpm_pkg::S_A_GOT: begin
        if (found_r) begin
          cursor_nxt = sc_r;
          plen_nxt   = plen_r + 1'b1;
        end else if (ncount_r >= mpm_pkg::CNT_W'(mpm_pkg::MAX_NODES)) begin
          pdrop_nxt   = 1'b1;
          preason_nxt = mpm_pkg::ST_FULL;
        end
      end
      mpm_pkg::S_A_NEW: begin
        node_we          = 1'b1;
        node_waddr       = ncount_r[mpm_pkg::NW-1:0];
        node_wdata       = '0;
        node_wdata.nbyte = byte_r;
        node_wdata.sib   = fw_r.child;
      end
      mpm_pkg::S_A_PAR: begin
        node_we          = 1'b1;
        node_waddr       = cursor_r;
        node_wdata       = fw_r;
        node_wdata.child = ncount_r[mpm_pkg::NW-1:0];
        cursor_nxt       = ncount_r[mpm_pkg::NW-1:0];
        ncount_nxt       = ncount_r + 1'b1;
        plen_nxt         = plen_r + 1'b1;
      end
      mpm_pkg::S_A_FIN: begin
        node_raddr = cursor_r;
        if (!(fin_r && !pdrop_r)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pdrop_r ? preason_r : mpm_pkg::ST_OK;
          if (fin_r) begin
            cursor_nxt  = '0;
            plen_nxt    = '0;
            pdrop_nxt   = 1'b0;
            preason_nxt = mpm_pkg::ST_OK;
          end
        end
      end
      mpm_pkg::S_A_MRK: begin
        node_we         = 1'b1;
        node_waddr      = cursor_r;
        node_wdata      = node_rdata;
        node_wdata.mark = 1'b1;
        node_wdata.pid  = pcount_r;
        out_valid_nxt   = 1'b1;
        out_id_nxt      = pcount_r;
        pcount_nxt      = pcount_r + 1'b1;
        cursor_nxt      = '0;
        plen_nxt        = '0;
        pdrop_nxt       = 1'b0;
        preason_nxt     = mpm_pkg::ST_OK;
      end
      mpm_pkg::S_M_GOT: begin
        if (found_r) begin
          cursor_nxt = sc_r;
          f_nxt      = sc_r;
        end else if (fnode_r == '0) begin
          cursor_nxt = '0;
          f_nxt      = '0;
        end else begin
          fnode_nxt = fw_r.fail;
        end
      end
      mpm_pkg::S_M_CH: begin
        node_raddr = f_r;
        if (f_r == '0) begin
          out_valid_nxt = 1'b1;
        end
      end
      mpm_pkg::S_M_CW: begin
        f_nxt = node_rdata.fail;
        if (node_rdata.mark) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = mpm_pkg::KIND_MATCH;
          out_id_nxt    = node_rdata.pid;
          out_last_nxt  = 1'b0;
        end
      end
      mpm_pkg::S_B_INIT: begin
        q_we     = 1'b1;
        head_nxt = '0;
        tail_nxt = mpm_pkg::CNT_W'(1);
      end
      mpm_pkg::S_B_POP: begin
        q_raddr = head_r[mpm_pkg::NW-1:0];
        if (head_r == tail_r) begin
          out_valid_nxt = 1'b1;
        end else begin
          head_nxt = head_r + 1'b1;
        end
      end
      mpm_pkg::S_B_QW: begin
        now_nxt    = q_rdata;
        node_raddr = q_rdata;
      end
      mpm_pkg::S_B_NW: begin
        nf_nxt = node_rdata.fail;
        c_nxt  = node_rdata.child;
      end
      mpm_pkg::S_B_C: begin
        node_raddr = c_r;
      end
      mpm_pkg::S_B_CW: begin
        cw_nxt    = node_rdata;
        found_nxt = 1'b0;
        fnode_nxt = nf_r;
        fbyte_nxt = node_rdata.nbyte;
        ret_nxt   = mpm_pkg::S_B_GOT;
      end
      mpm_pkg::S_B_GOT: begin
        if (!found_r && fnode_r != '0) begin
          fnode_nxt = fw_r.fail;
        end
      end
      mpm_pkg::S_B_WR: begin
        node_we         = 1'b1;
        node_waddr      = c_r;
        node_wdata      = cw_r;
        node_wdata.fail = found_r ? sc_r : '0;
        if (tail_r < mpm_pkg::CNT_W'(mpm_pkg::MAX_NODES)) begin
          q_we     = 1'b1;
          q_waddr  = tail_r[mpm_pkg::NW-1:0];
          q_wdata  = c_r;
          tail_nxt = tail_r + 1'b1;
        end
        c_nxt = cw_r.sib;
      end
      default: begin
        node_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpm_pkg::S_INIT;
      ret_r       <= mpm_pkg::S_IDLE;
      cursor_r    <= '0;
      ncount_r    <= mpm_pkg::CNT_W'(1);
      pcount_r    <= '0;
      plen_r      <= '0;
      pdrop_r     <= 1'b0;
      preason_r   <= mpm_pkg::ST_OK;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cursor_r    <= cursor_nxt;
      ncount_r    <= ncount_nxt;
      pcount_r    <= pcount_nxt;
      plen_r      <= plen_nxt;
      pdrop_r     <= pdrop_nxt;
      preason_r   <= preason_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    fin_r        <= fin_nxt;
    fbyte_r      <= fbyte_nxt;
    fnode_r      <= fnode_nxt;
    sc_r         <= sc_nxt;
    found_r      <= found_nxt;
    fw_r         <= fw_nxt;
    cw_r         <= cw_nxt;
    f_r          <= f_nxt;
    now_r        <= now_nxt;
    nf_r         <= nf_nxt;
    c_r          <= c_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("transaction accepted but block not busy");

  a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == mpm_pkg::KIND_MATCH |-> out_status == mpm_pkg::ST_OK && !out_last)
    else $error("match report with bad status or last flag");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("non-final result while idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> ncount_r >= mpm_pkg::CNT_W'(1) && ncount_r <= mpm_pkg::CNT_W'(mpm_pkg::MAX_NODES))
    else $error("node count out of range");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mpm_pkg::S_B_QW |-> head_r <= tail_r) else $error("queue head passed tail");

endmodule
`default_nettype wire
